[rtl/chbg_pkg.sv]
`timescale 1ns / 1ps

package chbg_pkg;

   localparam int MAX_BATCHES_DEFAULT = 64;
   localparam int BATCH_INDEX_W = 6;
   localparam int HASH_W = 64;
   localparam int COUNT_W = 32;

   // The three size fields of one mesh and its content hash.
   typedef struct packed {
      logic [HASH_W-1:0]  mesh_hash;
      logic [COUNT_W-1:0] position_count;
      logic [COUNT_W-1:0] normal_count;
      logic [COUNT_W-1:0] index_count;
   } mesh_type;

   // Per-batch update strobes, applied in this order: clear, drop, write.
   typedef struct packed {
      logic clear;
      logic drop;
      logic write;
   } cell_ctrl_type;

   typedef struct packed {
      logic own;
      logic key_hit;
      logic size_hit;
   } cell_status_type;

endpackage

[rtl/chbg_cell.sv]
`timescale 1ns / 1ps

module chbg_cell
   import chbg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cell_ctrl_type   ctrl,
   input  mesh_type        mesh,
   output cell_status_type status
);

   logic     own_ff;
   logic     own_in;
   mesh_type entry_ff;

   always_comb begin
      own_in = own_ff;
      if (ctrl.clear) begin
         own_in = 1'b0;
      end
      if (ctrl.drop) begin
         own_in = 1'b0;
      end
      if (ctrl.write) begin
         own_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= 1'b0;
      end else begin
         own_ff <= own_in;
      end
   end

   // The stored hash and sizes are only looked at while the entry is owned.
   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         entry_ff <= mesh;
      end
   end

   always_comb begin
      status.own      = own_ff;
      status.key_hit  = own_ff && (entry_ff.mesh_hash == mesh.mesh_hash);
      status.size_hit = status.key_hit
                        && (entry_ff.position_count == mesh.position_count)
                        && (entry_ff.normal_count == mesh.normal_count)
                        && (entry_ff.index_count == mesh.index_count);
   end

endmodule

[rtl/content_hash_batch_grouper_core.sv]
`timescale 1ns / 1ps

// Groups meshes into instancing batches by their 64-bit content hash. Each request
// transaction carries a hash and the position, normal and index counts of one mesh;
// req_tuser set marks the first mesh of a scene and empties the batch table first.
// Every batch entry compares its own hash and counts against the incoming mesh in
// parallel, so the block takes one transaction per cycle while the response side is
// not stalled; rsp_tvalid rises once the mesh has passed the input register and then
// the compare and result register.
// A mesh with no positions or no indices is skipped; a mesh whose hash owner has
// other counts, or whose hash is new, opens the next batch, and table_full reports
// that all MAX_BATCHES entries are in use. Every request yields one response.
module content_hash_batch_grouper_core
   import chbg_pkg::*;
#(
   parameter int MAX_BATCHES = MAX_BATCHES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mesh_hash[63:0], position_count[95:64], normal_count[127:96], index_count[159:128]
   input  logic [159:0] req_tdata,
   // first_of_scene[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // batch_index[5:0], zero fill [7:6]
   output logic [7:0]   rsp_tdata,
   // opened_new[0], skipped[1], table_full[2]
   output logic [2:0]   rsp_tuser
);

   localparam int IDX_W = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
   localparam int CNT_W = $clog2(MAX_BATCHES + 1);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic                 in_scene_ff;
   mesh_type             in_mesh_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [BATCH_INDEX_W-1:0] out_index_ff;
   logic [2:0]           out_flags_ff;
   logic [CNT_W-1:0]     batch_count_ff;
   logic [CNT_W-1:0]     batch_count_in;

   logic                 advance;
   logic                 req_accept;
   logic [CNT_W-1:0]     eff_count;
   logic [MAX_BATCHES-1:0] own_vec;
   logic [MAX_BATCHES-1:0] hit_vec;
   logic [MAX_BATCHES-1:0] size_vec;
   logic                 match;
   logic                 skip;
   logic                 space;
   logic                 open_new;
   logic                 full;
   logic [IDX_W-1:0]     owner;
   logic [IDX_W-1:0]     slot;
   logic [IDX_W-1:0]     result_slot;
   logic [IDX_W+BATCH_INDEX_W-1:0] slot_ext;

   cell_ctrl_type        cell_ctrl   [MAX_BATCHES];
   cell_status_type      cell_status [MAX_BATCHES];

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_scene_ff               <= req_tuser;
         in_mesh_ff.mesh_hash      <= req_tdata[63:0];
         in_mesh_ff.position_count <= req_tdata[95:64];
         in_mesh_ff.normal_count   <= req_tdata[127:96];
         in_mesh_ff.index_count    <= req_tdata[159:128];
      end
   end

   // A scene start empties the table before the lookup, so it masks all hits.
   genvar g;
   generate
      for (g = 0; g < MAX_BATCHES; g++) begin : g_cell
         assign own_vec[g]  = cell_status[g].own;
         assign hit_vec[g]  = cell_status[g].key_hit && !in_scene_ff;
         assign size_vec[g] = cell_status[g].size_hit && !in_scene_ff;

         assign cell_ctrl[g].clear = advance && in_scene_ff;
         assign cell_ctrl[g].drop  = advance && open_new && hit_vec[g];
         assign cell_ctrl[g].write = advance && open_new && (slot == IDX_W'(g));

         chbg_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (cell_ctrl[g]),
            .mesh   (in_mesh_ff),
            .status (cell_status[g])
         );
      end
   endgenerate

   // At most one owned entry holds a given hash, so OR-ing the indexes encodes it.
   always_comb begin
      owner = '0;
      for (int i = 0; i < MAX_BATCHES; i++) begin
         if (hit_vec[i]) begin
            owner = owner | IDX_W'(i);
         end
      end
   end

   assign eff_count = in_scene_ff ? '0 : batch_count_ff;
   assign slot      = eff_count[IDX_W-1:0];
   assign match     = |size_vec;
   assign skip      = (in_mesh_ff.position_count == '0) || (in_mesh_ff.index_count == '0);
   assign space     = eff_count < CNT_W'(MAX_BATCHES);
   assign open_new  = !skip && !match && space;
   assign full      = !skip && !match && !space;

   always_comb begin
      result_slot = '0;
      if (!skip && match) begin
         result_slot = owner;
      end else if (open_new) begin
         result_slot = slot;
      end
   end

   assign slot_ext = {{BATCH_INDEX_W{1'b0}}, result_slot};

   always_comb begin
      batch_count_in = batch_count_ff;
      if (advance) begin
         batch_count_in = eff_count + CNT_W'(open_new);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_count_ff <= '0;
      end else begin
         batch_count_ff <= batch_count_in;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_index_ff <= slot_ext[BATCH_INDEX_W-1:0];
         out_flags_ff <= {full, skip, open_new};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_index_ff};
   assign rsp_tuser  = out_flags_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      batch_count_ff <= CNT_W'(MAX_BATCHES))
      else $error("batch count exceeds capacity");

   a_owner_unique: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> $onehot0(hit_vec))
      else $error("more than one batch owns the same hash");

   a_owners_counted: assert property (@(posedge clock) disable iff (reset)
      $countones(own_vec) <= int'(batch_count_ff))
      else $error("more owning batches than opened batches");

   a_open_counts: assert property (@(posedge clock) disable iff (reset)
      (advance && open_new) |=> (batch_count_ff == CNT_W'($past(eff_count) + 1'b1)))
      else $error("opening a batch did not advance the batch count");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0(out_flags_ff))
      else $error("response flags are not mutually exclusive");

endmodule

[tb/batch_grouper_checker.sv]
`timescale 1ns / 1ps

module batch_grouper_checker
   import chbg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [159:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [7:0]   rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   output int           mismatch_count,
   output int           pending
);

   localparam int BATCHES = MAX_BATCHES_DEFAULT;

   typedef struct packed {
      logic [BATCH_INDEX_W-1:0] batch_index;
      logic                     opened_new;
      logic                     skipped;
      logic                     table_full;
   } grouping_type;

   logic [HASH_W-1:0]  batch_key       [BATCHES];
   logic [COUNT_W-1:0] batch_positions [BATCHES];
   logic [COUNT_W-1:0] batch_normals   [BATCHES];
   logic [COUNT_W-1:0] batch_indices   [BATCHES];
   logic               batch_holds_key [BATCHES];
   int                 open_batches;
   grouping_type       expected_groupings [$];

   initial begin
      mismatch_count = 0;
      pending = 0;
   end

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   function automatic void clear_batches();
      foreach (batch_holds_key[i]) batch_holds_key[i] = 1'b0;
      open_batches = 0;
   endfunction

   // Works out where one mesh lands and updates the batch table to match.
   function automatic grouping_type group_mesh(logic scene_start, mesh_type mesh);
      grouping_type g;
      int           owner;
      int           i;
      g = '0;
      owner = -1;
      if (scene_start) begin
         clear_batches();
      end
      if (mesh.position_count == '0 || mesh.index_count == '0) begin
         g.skipped = 1'b1;
      end else begin
         for (i = 0; i < BATCHES; i++) begin
            if (owner < 0 && batch_holds_key[i] && batch_key[i] == mesh.mesh_hash) begin
               owner = i;
            end
         end
         if (owner >= 0 && batch_positions[owner] == mesh.position_count &&
             batch_normals[owner] == mesh.normal_count &&
             batch_indices[owner] == mesh.index_count) begin
            g.batch_index = BATCH_INDEX_W'(owner);
         end else if (open_batches < BATCHES) begin
            // The new batch takes the hash over from its previous owner.
            if (owner >= 0) begin
               batch_holds_key[owner] = 1'b0;
            end
            batch_key[open_batches]       = mesh.mesh_hash;
            batch_positions[open_batches] = mesh.position_count;
            batch_normals[open_batches]   = mesh.normal_count;
            batch_indices[open_batches]   = mesh.index_count;
            batch_holds_key[open_batches] = 1'b1;
            g.batch_index = BATCH_INDEX_W'(open_batches);
            g.opened_new = 1'b1;
            open_batches++;
         end else begin
            g.table_full = 1'b1;
         end
      end
      return g;
   endfunction

   always @(posedge clock) begin : watch
      grouping_type want;
      mesh_type     mesh;
      if (reset) begin
         clear_batches();
         expected_groupings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_groupings.size() == 0) begin
               report_mismatch("response with no request waiting", 0, rsp_tdata);
            end else begin
               want = expected_groupings.pop_front();
               if (rsp_tdata[BATCH_INDEX_W-1:0] != want.batch_index) begin
                  report_mismatch("batch_index", want.batch_index,
                                  rsp_tdata[BATCH_INDEX_W-1:0]);
               end
               if (rsp_tuser[0] != want.opened_new) begin
                  report_mismatch("opened_new", want.opened_new, rsp_tuser[0]);
               end
               if (rsp_tuser[1] != want.skipped) begin
                  report_mismatch("skipped", want.skipped, rsp_tuser[1]);
               end
               if (rsp_tuser[2] != want.table_full) begin
                  report_mismatch("table_full", want.table_full, rsp_tuser[2]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            mesh.mesh_hash      = req_tdata[63:0];
            mesh.position_count = req_tdata[95:64];
            mesh.normal_count   = req_tdata[127:96];
            mesh.index_count    = req_tdata[159:128];
            want = group_mesh(req_tuser, mesh);
            expected_groupings.insert(expected_groupings.size(), want);
         end
      end
      pending <= expected_groupings.size();
   end

endmodule

[tb/content_hash_batch_grouper_core_tb.sv]
`timescale 1ns / 1ps

module content_hash_batch_grouper_core_tb;
   import chbg_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1750;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic [2:0]   rsp_tuser;

   int   mismatch_count;
   int   pending;
   int   send_idle_pct = 6;
   int   recv_idle_pct = 77;
   logic calm_stretch = 1'b0;
   int   items_sent = 0;
   int   stall_cycles = 0;

   content_hash_batch_grouper_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   batch_grouper_checker grouping_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= calm_stretch || ($urandom_range(99) >= recv_idle_pct);
   end

   // Ends the run when neither channel has moved a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Called at a rising edge; returns at the edge where the mesh was accepted.
   task automatic send_mesh(logic scene_start, logic [63:0] hash, logic [31:0] positions,
                            logic [31:0] normals, logic [31:0] indices);
      while (!calm_stretch && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= scene_start;
      req_tdata  <= {indices, normals, positions, hash};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   initial begin : stimulus
      logic [63:0] pool_hash [128];
      logic [31:0] pool_pos  [128];
      logic [31:0] pool_nrm  [128];
      logic [31:0] pool_idx  [128];
      logic [31:0] positions;
      logic [31:0] normals;
      logic [31:0] indices;
      int          scene_len;
      int          pool_size;
      int          pick;
      int          roll;
      int          k;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Joins, changed counts taking a hash over, skips, and scene starts.
      send_mesh(1'b1, 64'h0, ALL_ONES, ALL_ONES, ALL_ONES);
      send_mesh(1'b0, 64'h0, ALL_ONES, ALL_ONES, ALL_ONES);
      send_mesh(1'b0, '1, 32'd1, 32'd0, 32'd1);
      send_mesh(1'b0, '1, 32'd1, 32'd0, 32'd1);
      send_mesh(1'b0, 64'h0, ALL_ONES, 32'd0, ALL_ONES);
      send_mesh(1'b0, 64'h0, ALL_ONES, ALL_ONES, ALL_ONES);
      send_mesh(1'b0, 64'h0, ALL_ONES, ALL_ONES, ALL_ONES);
      send_mesh(1'b0, 64'h5, 32'd0, 32'd7, 32'd9);
      send_mesh(1'b0, 64'h5, 32'd7, 32'd7, 32'd0);
      send_mesh(1'b0, 64'h5, 32'd0, 32'd0, 32'd0);
      send_mesh(1'b0, '1, 32'd1, 32'd0, 32'd1);
      // A skipped mesh that starts a scene still empties the table.
      send_mesh(1'b1, '1, 32'd0, 32'd1, 32'd1);
      send_mesh(1'b0, '1, 32'd1, 32'd0, 32'd1);
      send_mesh(1'b0, 64'hA5A5_5A5A_C3C3_3C3C, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_mesh(1'b1, 64'hA5A5_5A5A_C3C3_3C3C, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_mesh(1'b0, 64'hA5A5_5A5A_C3C3_3C3C, 32'h8000_0000, 32'h8000_0000, 32'd1);
      send_mesh(1'b0, 64'hA5A5_5A5A_C3C3_3C3C, 32'd3, 32'h8000_0000, 32'd1);
      send_mesh(1'b0, 64'hA5A5_5A5A_C3C3_3C3C, 32'd3, 32'h8000_0000, 32'd1);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent < 600) begin
            send_idle_pct = 6;
            recv_idle_pct <= 77;
         end else if (items_sent < 1200) begin
            send_idle_pct = 77;
            recv_idle_pct <= 6;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         calm_stretch <= ($urandom_range(4) == 0);

         // Long scenes walk through more hashes than there are batches.
         if ($urandom_range(5) == 0) begin
            scene_len = $urandom_range(140, 70);
            pool_size = $urandom_range(128, 66);
         end else begin
            scene_len = $urandom_range(40, 4);
            pool_size = $urandom_range(16, 1);
         end
         for (k = 0; k < pool_size; k++) begin
            pool_hash[k] = {$urandom, $urandom};
            pool_pos[k]  = ($urandom_range(1) == 0) ? $urandom_range(300, 1) : $urandom;
            pool_nrm[k]  = ($urandom_range(1) == 0) ? $urandom_range(300) : $urandom;
            pool_idx[k]  = ($urandom_range(1) == 0) ? $urandom_range(900, 1) : $urandom;
         end

         for (k = 0; k < scene_len; k++) begin
            pick = (scene_len > 60) ? (k % pool_size) : $urandom_range(pool_size - 1);
            roll = $urandom_range(99);
            positions = pool_pos[pick];
            normals   = pool_nrm[pick];
            indices   = pool_idx[pick];
            if (roll < 12) begin
               case ($urandom_range(2))
                  0: positions = $urandom;
                  1: normals = $urandom;
                  default: indices = $urandom;
               endcase
            end else if (roll < 20) begin
               if ($urandom_range(1) == 0) begin
                  positions = '0;
               end else begin
                  indices = '0;
               end
            end
            send_mesh(k == 0 || roll == 99, pool_hash[pick], positions, normals, indices);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
